// ===== rtl/core/tcw_pkg.sv =====
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared types and constants of the text console writer: opcodes, the
// classified command that passes from the front end to the executor, and
// the character codes.
// ----------------------------------------------------------------------------
`default_nettype none

package tcw_pkg;

  localparam int DEF_COLUMNS = 80;
  localparam int DEF_ROWS    = 25;

  localparam logic [7:0] NEWLINE_CODE = 8'd10;
  localparam logic [7:0] BLANK_CODE   = 8'd32;
  localparam logic [7:0] RESET_ATTR   = 8'd15;

  typedef enum logic [2:0] {
    OP_PUT_CHAR  = 3'd0,
    OP_CLEAR_ROW = 3'd1,
    OP_CLEAR_ALL = 3'd2,
    OP_SET_ATTR  = 3'd3,
    OP_READ_CELL = 3'd4
  } opcode_t;

  typedef enum logic [2:0] {
    K_PUT,
    K_CLEAR_ROW,
    K_CLEAR_ALL,
    K_SET_ATTR,
    K_READ,
    K_NOP
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t  kind;
    logic       err;
    logic       newline;
    logic [7:0] ch;
    logic [4:0] row;
    logic [6:0] col;
    logic [7:0] attr;
  } cmd_t;

endpackage

`default_nettype wire

// ===== rtl/core/tcw_if.sv =====
// ----------------------------------------------------------------------------
// tcw_if
// Valid/ready channels of the text console writer: the request channel
// carrying one operation and the response channel carrying its result.
// ----------------------------------------------------------------------------
`default_nettype none

interface tcw_req_if;
  logic       valid;
  logic       ready;
  logic [2:0] opcode;
  logic [7:0] char_code;
  logic [4:0] row_index;
  logic [6:0] read_column;
  logic [7:0] new_attribute;

  modport source (output valid, opcode, char_code, row_index, read_column,
                  new_attribute, input ready);
  modport sink   (input valid, opcode, char_code, row_index, read_column,
                  new_attribute, output ready);
endinterface

interface tcw_rsp_if;
  logic        valid;
  logic        ready;
  logic        status;
  logic [6:0]  cursor_column;
  logic [4:0]  cursor_row;
  logic [7:0]  attribute;
  logic [15:0] cell_word;

  modport source (output valid, status, cursor_column, cursor_row, attribute,
                  cell_word, input ready);
  modport sink   (input valid, status, cursor_column, cursor_row, attribute,
                  cell_word, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/tcw_front.sv =====
// ----------------------------------------------------------------------------
// tcw_front
// Request front end: accepts items, range-checks rows and columns, turns the
// opcode into a command kind and registers the command for the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_front #(
  parameter int SCREEN_COLUMNS = tcw_pkg::DEF_COLUMNS,
  parameter int SCREEN_ROWS    = tcw_pkg::DEF_ROWS
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          init_done,
  tcw_req_if.sink            req,
  output tcw_pkg::cmd_t      push_cmd,
  output logic               push_valid,
  input  wire logic          push_ready
);
  import tcw_pkg::*;

  logic stage_valid;
  cmd_t stage_cmd;
  cmd_t cmd_next;
  logic row_bad;
  logic col_bad;

  assign row_bad = req.row_index >= 5'(SCREEN_ROWS);
  assign col_bad = req.read_column >= 7'(SCREEN_COLUMNS);

  always_comb begin
    cmd_next.kind    = K_NOP;
    cmd_next.err     = 1'b0;
    cmd_next.newline = req.char_code == NEWLINE_CODE;
    cmd_next.ch      = req.char_code;
    cmd_next.row     = req.row_index;
    cmd_next.col     = req.read_column;
    cmd_next.attr    = req.new_attribute;
    case (req.opcode)
      OP_PUT_CHAR:  cmd_next.kind = K_PUT;
      OP_CLEAR_ROW: begin
        if (row_bad) begin
          cmd_next.err = 1'b1;
        end else begin
          cmd_next.kind = K_CLEAR_ROW;
        end
      end
      OP_CLEAR_ALL: cmd_next.kind = K_CLEAR_ALL;
      OP_SET_ATTR:  cmd_next.kind = K_SET_ATTR;
      OP_READ_CELL: begin
        if (row_bad || col_bad) begin
          cmd_next.err = 1'b1;
        end else begin
          cmd_next.kind = K_READ;
        end
      end
      default:      cmd_next.kind = K_NOP;
    endcase
  end

  // hold off new items during the post-reset clearing pass
  assign req.ready  = init_done && (!stage_valid || push_ready);
  assign push_valid = stage_valid;
  assign push_cmd   = stage_cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (req.valid && req.ready) begin
      stage_valid <= 1'b1;
    end else if (push_ready) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      stage_cmd <= cmd_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/tcw_cmd_queue.sv =====
// ----------------------------------------------------------------------------
// tcw_cmd_queue
// Two-entry command queue between the front end and the executor.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_cmd_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire tcw_pkg::cmd_t push_cmd,
  input  wire logic          push_valid,
  output logic               push_ready,
  output tcw_pkg::cmd_t      pop_cmd,
  output logic               pop_valid,
  input  wire logic          pop
);
  import tcw_pkg::*;

  cmd_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign push_ready = count != 2'd2;
  assign pop_valid  = count != 2'd0;
  assign pop_cmd    = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (do_push && !do_pop) begin
        count <= count + 2'd1;
      end else if (do_pop && !do_push) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/tcw_back.sv =====
// ----------------------------------------------------------------------------
// tcw_back
// Executor: owns the screen memory, cursor and attribute. Runs one command
// at a time, sweeping the memory for clears and scrolls, and registers the
// result for the response channel.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_back #(
  parameter int SCREEN_COLUMNS = tcw_pkg::DEF_COLUMNS,
  parameter int SCREEN_ROWS    = tcw_pkg::DEF_ROWS
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire tcw_pkg::cmd_t q_cmd,
  input  wire logic          q_valid,
  output logic               q_pop,
  output logic               init_done,
  tcw_rsp_if.source          rsp
);
  import tcw_pkg::*;

  localparam int DEPTH  = SCREEN_COLUMNS * SCREEN_ROWS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam logic [ADDR_W-1:0] LAST_A      = ADDR_W'(DEPTH - 1);
  localparam logic [ADDR_W-1:0] KEEP_A      = ADDR_W'(DEPTH - SCREEN_COLUMNS);
  localparam logic [ADDR_W-1:0] RD_STOP_A   = ADDR_W'(DEPTH - SCREEN_COLUMNS - 1);
  localparam logic [ADDR_W-1:0] COLS_A      = ADDR_W'(SCREEN_COLUMNS);
  localparam logic [ADDR_W-1:0] COLS_M1_A   = ADDR_W'(SCREEN_COLUMNS - 1);
  localparam logic [ADDR_W-1:0] COLS_P1_A   = ADDR_W'(SCREEN_COLUMNS + 1);
  localparam logic [ADDR_W-1:0] ONE_A       = ADDR_W'(1);
  localparam logic [6:0]        COLS_C      = 7'(SCREEN_COLUMNS);
  localparam logic [4:0]        LAST_ROW    = 5'(SCREEN_ROWS - 1);

  typedef enum logic [2:0] {
    S_FILL,
    S_IDLE,
    S_PUT,
    S_SCROLL_PRIME,
    S_SCROLL,
    S_READ_WAIT,
    S_FINISH
  } state_t;

  state_t state;

  logic [15:0]       mem [DEPTH];
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [15:0]       mem_wdata;
  logic              mem_re;
  logic [ADDR_W-1:0] mem_raddr;
  logic [15:0]       mem_rdata;

  logic [6:0]        col_pos;
  logic [4:0]        row_pos;
  logic [7:0]        attr;
  cmd_t              cur;
  logic [1:0]        nl_left;
  logic [ADDR_W-1:0] sweep_addr;
  logic [ADDR_W-1:0] sweep_end;
  logic [15:0]       fill_word;
  logic              res_valid;
  logic              res_err;
  logic [15:0]       res_cell;
  logic              res_status;
  logic [6:0]        res_col;
  logic [4:0]        res_row;
  logic [7:0]        res_attr;

  logic [4:0]        row_sel;
  logic [ADDR_W-1:0] row_base;
  logic [15:0]       blank_word;
  logic              start;

  assign blank_word = {attr, BLANK_CODE};
  assign start      = (state == S_IDLE) && q_valid && !res_valid;
  assign q_pop      = start;

  // row * columns, shared by put, read and clear row
  assign row_sel  = (state == S_PUT) ? row_pos : q_cmd.row;
  assign row_base = ADDR_W'(row_sel) * COLS_A;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = sweep_addr;
    mem_wdata = fill_word;
    mem_re    = 1'b0;
    mem_raddr = sweep_addr + COLS_P1_A;
    case (state)
      S_FILL: mem_we = 1'b1;
      S_SCROLL: begin
        mem_we    = 1'b1;
        mem_wdata = (sweep_addr < KEEP_A) ? mem_rdata : blank_word;
        mem_re    = sweep_addr < RD_STOP_A;
      end
      S_SCROLL_PRIME: begin
        mem_re    = 1'b1;
        mem_raddr = COLS_A;
      end
      S_PUT: begin
        mem_we    = (nl_left == 2'd0) && !cur.newline;
        mem_waddr = row_base + ADDR_W'(col_pos);
        mem_wdata = {attr, cur.ch};
      end
      S_IDLE: begin
        mem_re    = start && (q_cmd.kind == K_READ);
        mem_raddr = row_base + ADDR_W'(q_cmd.col);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_FILL;
      init_done  <= 1'b0;
      col_pos    <= 7'd0;
      row_pos    <= 5'd0;
      attr       <= RESET_ATTR;
      nl_left    <= 2'd0;
      sweep_addr <= '0;
      sweep_end  <= LAST_A;
      fill_word  <= 16'd0;
      res_valid  <= 1'b0;
      res_err    <= 1'b0;
      res_cell   <= 16'd0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_FILL: begin
          if (sweep_addr == sweep_end) begin
            if (init_done) begin
              state <= S_FINISH;
            end else begin
              init_done <= 1'b1;
              state     <= S_IDLE;
            end
          end else begin
            sweep_addr <= sweep_addr + ONE_A;
          end
        end
        S_IDLE: begin
          if (start) begin
            cur      <= q_cmd;
            res_err  <= q_cmd.err;
            res_cell <= 16'd0;
            case (q_cmd.kind)
              K_PUT: begin
                nl_left <= {1'b0, col_pos >= COLS_C} + {1'b0, q_cmd.newline};
                state   <= S_PUT;
              end
              K_CLEAR_ROW: begin
                sweep_addr <= row_base;
                sweep_end  <= row_base + COLS_M1_A;
                fill_word  <= blank_word;
                state      <= S_FILL;
              end
              K_CLEAR_ALL: begin
                sweep_addr <= '0;
                sweep_end  <= LAST_A;
                fill_word  <= blank_word;
                state      <= S_FILL;
              end
              K_SET_ATTR: begin
                attr  <= q_cmd.attr;
                state <= S_FINISH;
              end
              K_READ:  state <= S_READ_WAIT;
              default: state <= S_FINISH;
            endcase
          end
        end
        S_PUT: begin
          if (nl_left != 2'd0) begin
            col_pos <= 7'd0;
            nl_left <= nl_left - 2'd1;
            if (row_pos < LAST_ROW) begin
              row_pos <= row_pos + 5'd1;
            end else begin
              state <= S_SCROLL_PRIME;
            end
          end else begin
            if (!cur.newline) begin
              col_pos <= col_pos + 7'd1;
            end
            state <= S_FINISH;
          end
        end
        S_SCROLL_PRIME: begin
          sweep_addr <= '0;
          state      <= S_SCROLL;
        end
        S_SCROLL: begin
          // shift every row up one, then blank the last row
          if (sweep_addr == LAST_A) begin
            state <= S_PUT;
          end else begin
            sweep_addr <= sweep_addr + ONE_A;
          end
        end
        S_READ_WAIT: begin
          res_cell <= mem_rdata;
          state    <= S_FINISH;
        end
        S_FINISH: begin
          res_valid  <= 1'b1;
          res_status <= res_err;
          res_col    <= col_pos;
          res_row    <= row_pos;
          res_attr   <= attr;
          state      <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign rsp.valid         = res_valid;
  assign rsp.status        = res_status;
  assign rsp.cursor_column = res_col;
  assign rsp.cursor_row    = res_row;
  assign rsp.attribute     = res_attr;
  assign rsp.cell_word     = res_cell;

endmodule

`default_nettype wire

// ===== rtl/core/text_console_writer.sv =====
// Text console writer. Owns a SCREEN_ROWS x SCREEN_COLUMNS screen of 16-bit
// cells (attribute high byte, character low byte) and runs one operation per
// request item, returning one response item with the cursor and attribute.
// All work goes through a single screen memory with one write and one read
// port, so an operation takes longer the more cells it touches: a clear
// sweeps its row or the whole screen, and each scroll sweeps the whole
// screen. After reset the memory is swept to zero, one cell a cycle, with
// req.ready low. Requests queue up (two deep plus one front register) while
// an operation runs or a response waits.
// ----------------------------------------------------------------------------
// text_console_writer
// Top level: front end, command queue and executor.
// ----------------------------------------------------------------------------
`default_nettype none

module text_console_writer #(
  parameter int SCREEN_COLUMNS = tcw_pkg::DEF_COLUMNS,
  parameter int SCREEN_ROWS    = tcw_pkg::DEF_ROWS
) (
  input  wire logic clk,
  input  wire logic rst,
  tcw_req_if.sink   req,
  tcw_rsp_if.source rsp
);
  import tcw_pkg::*;

  cmd_t push_cmd;
  logic push_valid;
  logic push_ready;
  cmd_t pop_cmd;
  logic pop_valid;
  logic pop;
  logic init_done;

  tcw_front #(
    .SCREEN_COLUMNS (SCREEN_COLUMNS),
    .SCREEN_ROWS    (SCREEN_ROWS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .init_done  (init_done),
    .req        (req),
    .push_cmd   (push_cmd),
    .push_valid (push_valid),
    .push_ready (push_ready)
  );

  tcw_cmd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_cmd   (push_cmd),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .pop_cmd    (pop_cmd),
    .pop_valid  (pop_valid),
    .pop        (pop)
  );

  tcw_back #(
    .SCREEN_COLUMNS (SCREEN_COLUMNS),
    .SCREEN_ROWS    (SCREEN_ROWS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_cmd     (pop_cmd),
    .q_valid   (pop_valid),
    .q_pop     (pop),
    .init_done (init_done),
    .rsp       (rsp)
  );

  a_no_accept_during_init: assert property (@(posedge clk) disable iff (rst)
    !init_done |-> !req.ready)
    else $error("request taken during clearing pass");

  a_column_in_range: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> rsp.cursor_column <= 7'(SCREEN_COLUMNS))
    else $error("cursor column beyond screen width");

  a_row_in_range: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> rsp.cursor_row < 5'(SCREEN_ROWS))
    else $error("cursor row beyond screen height");

endmodule

`default_nettype wire

// ===== tb/tcw_console_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tcw_console_checker
// Passive checker for the text console writer. It keeps a shadow copy of the
// screen, cursor and attribute. For every request item it computes the result
// the block must return, and it compares every response item, field by field,
// with the oldest result still outstanding.
// ----------------------------------------------------------------------------
module tcw_console_checker #(
  parameter int COLUMNS = tcw_pkg::DEF_COLUMNS,
  parameter int ROWS    = tcw_pkg::DEF_ROWS
) (
  input  logic clk,
  input  logic rst,
  tcw_req_if   req,
  tcw_rsp_if   rsp,
  output int   fail_count,
  output int   outstanding
);
  import tcw_pkg::*;

  typedef struct packed {
    logic        status;
    logic [6:0]  cursor_column;
    logic [4:0]  cursor_row;
    logic [7:0]  attribute;
    logic [15:0] cell_word;
  } console_result_t;

  logic [15:0]     screen_shadow [COLUMNS*ROWS];
  int              shadow_col;
  int              shadow_row;
  logic [7:0]      shadow_attr;
  console_result_t pending_results [$];
  int              mismatches = 0;
  int              pending_count = 0;

  assign fail_count  = mismatches;
  assign outstanding = pending_count;

  function automatic void blank_row(int r);
    for (int c = 0; c < COLUMNS; c++) begin
      screen_shadow[r*COLUMNS + c] = {shadow_attr, BLANK_CODE};
    end
  endfunction

  // Move to the start of the next line; scroll at the bottom row.
  function automatic void line_feed();
    shadow_col = 0;
    if (shadow_row < ROWS - 1) begin
      shadow_row++;
    end else begin
      for (int i = 0; i + COLUMNS < COLUMNS*ROWS; i++) begin
        screen_shadow[i] = screen_shadow[i + COLUMNS];
      end
      blank_row(ROWS - 1);
    end
  endfunction

  function automatic console_result_t predict_console_op(logic [2:0] op, logic [7:0] ch,
                                                         logic [4:0] row, logic [6:0] col,
                                                         logic [7:0] attr);
    console_result_t res;
    res = '0;
    case (op)
      OP_PUT_CHAR: begin
        if (shadow_col >= COLUMNS) line_feed();
        if (ch == NEWLINE_CODE) begin
          line_feed();
        end else begin
          screen_shadow[shadow_row*COLUMNS + shadow_col] = {shadow_attr, ch};
          shadow_col++;
        end
      end
      OP_CLEAR_ROW: begin
        if (row >= ROWS) res.status = 1'b1;
        else blank_row(row);
      end
      OP_CLEAR_ALL: begin
        for (int r = 0; r < ROWS; r++) blank_row(r);
      end
      OP_SET_ATTR: shadow_attr = attr;
      OP_READ_CELL: begin
        if (row >= ROWS || col >= COLUMNS) res.status = 1'b1;
        else res.cell_word = screen_shadow[row*COLUMNS + col];
      end
      default: ;
    endcase
    res.cursor_column = 7'(shadow_col);
    res.cursor_row    = 5'(shadow_row);
    res.attribute     = shadow_attr;
    return res;
  endfunction

  task automatic report_mismatch(string msg);
    $display("%0t ns: console mismatch: %s", $time, msg);
    mismatches++;
  endtask

  task automatic compare_field(string name, logic [15:0] got, logic [15:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got 0x%0h, expected 0x%0h", name, got, want));
    end
  endtask

  always @(posedge clk) begin
    console_result_t want;
    if (rst) begin
      foreach (screen_shadow[i]) screen_shadow[i] = '0;
      shadow_col  = 0;
      shadow_row  = 0;
      shadow_attr = RESET_ATTR;
      pending_results.delete();
    end else begin
      if (req.valid && req.ready) begin
        pending_results.push_back(predict_console_op(req.opcode, req.char_code,
                                                     req.row_index, req.read_column,
                                                     req.new_attribute));
      end
      if (rsp.valid && rsp.ready) begin
        if (pending_results.size() == 0) begin
          report_mismatch("response item with no request outstanding");
        end else begin
          want = pending_results.pop_front();
          compare_field("status", 16'(rsp.status), 16'(want.status));
          compare_field("cursor_column", 16'(rsp.cursor_column), 16'(want.cursor_column));
          compare_field("cursor_row", 16'(rsp.cursor_row), 16'(want.cursor_row));
          compare_field("attribute", 16'(rsp.attribute), 16'(want.attribute));
          compare_field("cell_word", rsp.cell_word, want.cell_word);
        end
      end
    end
    pending_count <= pending_results.size();
  end

endmodule

// ===== tb/text_console_writer_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// text_console_writer_test
// Drives the text console writer with a directed opening (field extremes,
// every opcode and range errors) and then with random lines of text mixed
// with reads, clears and attribute changes, under four idling schemes. A
// checker beside the block predicts and compares every response.
// ----------------------------------------------------------------------------
module text_console_writer_test;
  import tcw_pkg::*;

  localparam int COLS         = DEF_COLUMNS;
  localparam int ROWS         = DEF_ROWS;
  localparam int RANDOM_ITEMS = 1650;

  logic clk;
  logic rst;
  int   fail_count;
  int   outstanding;
  int   items_sent = 0;
  int   idle_pct = 0;
  int   stall_pct = 0;
  int   run_goal;

  tcw_req_if req_ch ();
  tcw_rsp_if rsp_ch ();

  text_console_writer dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  tcw_console_checker #(
    .COLUMNS (COLS),
    .ROWS    (ROWS)
  ) checker_i (
    .clk         (clk),
    .rst         (rst),
    .req         (req_ch),
    .rsp         (rsp_ch),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    rsp_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  task automatic send_op(logic [2:0] op, logic [7:0] ch, logic [4:0] row, logic [6:0] col,
                         logic [7:0] attr);
    while ($urandom_range(0, 99) < idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid         <= 1'b1;
    req_ch.opcode        <= op;
    req_ch.char_code     <= ch;
    req_ch.row_index     <= row;
    req_ch.read_column   <= col;
    req_ch.new_attribute <= attr;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic put_char(logic [7:0] ch);
    send_op(OP_PUT_CHAR, ch, 5'($urandom), 7'($urandom), 8'($urandom));
  endtask

  // Mostly on screen, sometimes anywhere the field reaches.
  function automatic logic [4:0] pick_row();
    return ($urandom_range(0, 99) < 85) ? 5'($urandom_range(0, ROWS - 1)) : 5'($urandom);
  endfunction

  function automatic logic [6:0] pick_col();
    return ($urandom_range(0, 99) < 85) ? 7'($urandom_range(0, COLS - 1)) : 7'($urandom);
  endfunction

  task automatic read_cell(logic [4:0] row, logic [6:0] col);
    send_op(OP_READ_CELL, 8'($urandom), row, col, 8'($urandom));
  endtask

  task automatic random_sequence();
    int          pick;
    int          len;
    logic [7:0]  ch;
    pick = $urandom_range(0, 99);
    if (pick < 60) begin
      // a line of text, now and then long enough to wrap
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(COLS - 5, COLS + 10)
                                        : $urandom_range(1, 30);
      for (int i = 0; i < len; i++) begin
        do ch = 8'($urandom); while (ch == NEWLINE_CODE);
        put_char(ch);
      end
      if ($urandom_range(0, 3) != 0) put_char(NEWLINE_CODE);
    end else if (pick < 70) begin
      send_op(OP_SET_ATTR, 8'($urandom), 5'($urandom), 7'($urandom), 8'($urandom));
    end else if (pick < 85) begin
      len = $urandom_range(1, 4);
      for (int i = 0; i < len; i++) read_cell(pick_row(), pick_col());
    end else if (pick < 91) begin
      send_op(OP_CLEAR_ROW, 8'($urandom), pick_row(), 7'($urandom), 8'($urandom));
    end else if (pick < 93) begin
      send_op(OP_CLEAR_ALL, 8'($urandom), 5'($urandom), 7'($urandom), 8'($urandom));
    end else if (pick < 96) begin
      send_op(3'($urandom_range(int'(OP_READ_CELL) + 1, 7)), 8'($urandom), 5'($urandom),
              7'($urandom), 8'($urandom));
    end else begin
      send_op(3'($urandom), 8'($urandom), 5'($urandom), 7'($urandom), 8'($urandom));
    end
  endtask

  initial begin
    rst                  = 1'b1;
    rsp_ch.ready         = 1'b0;
    req_ch.valid         = 1'b0;
    req_ch.opcode        = OP_PUT_CHAR;
    req_ch.char_code     = '0;
    req_ch.row_index     = '0;
    req_ch.read_column   = '0;
    req_ch.new_attribute = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed opening
    read_cell(5'd0, 7'd0);
    read_cell(5'(ROWS - 1), 7'(COLS - 1));
    read_cell(5'(ROWS), 7'd0);
    read_cell(5'd0, 7'(COLS));
    read_cell(5'h1f, 7'h7f);
    put_char(8'h00);
    put_char(8'hff);
    send_op(OP_SET_ATTR, 8'h00, 5'd0, 7'd0, 8'h00);
    put_char(8'h41);
    send_op(OP_SET_ATTR, 8'hff, 5'h1f, 7'h7f, 8'hff);
    put_char(8'h7f);
    put_char(NEWLINE_CODE);
    read_cell(5'd0, 7'd3);
    send_op(OP_CLEAR_ROW, 8'h00, 5'd0, 7'd0, 8'h00);
    send_op(OP_CLEAR_ROW, 8'h00, 5'(ROWS - 1), 7'd0, 8'h00);
    send_op(OP_CLEAR_ROW, 8'h00, 5'(ROWS), 7'd0, 8'h00);
    send_op(OP_CLEAR_ROW, 8'hff, 5'h1f, 7'h7f, 8'hff);
    read_cell(5'd0, 7'd0);
    for (int op = int'(OP_READ_CELL) + 1; op < 8; op++) begin
      send_op(3'(op), 8'hff, 5'h1f, 7'h7f, 8'hff);
    end
    send_op(OP_CLEAR_ALL, 8'h00, 5'd0, 7'd0, 8'h00);
    read_cell(5'(ROWS - 1), 7'(COLS - 1));
    send_op(OP_SET_ATTR, 8'h00, 5'd0, 7'd0, RESET_ATTR);

    // random part, one idling scheme per quarter
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 70; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 70; end
        default: begin idle_pct = 34; stall_pct = 34; end
      endcase
      run_goal = items_sent + RANDOM_ITEMS / 4;
      while (items_sent < run_goal) random_sequence();
    end
    req_ch.valid <= 1'b0;
    stall_pct = 0;

    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (64) @(posedge clk);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/tcw_pkg.sv
rtl/core/tcw_if.sv
rtl/core/tcw_front.sv
rtl/core/tcw_cmd_queue.sv
rtl/core/tcw_back.sv
rtl/core/text_console_writer.sv
tb/tcw_console_checker.sv
tb/text_console_writer_test.sv
